>>> design/scs_pkg.sv
// Shared constants, codes and control types of the shadow call stack checker.
// Depends on nothing; scs_ctrl, scs_datapath and the top level import it.
`default_nettype none

package scs_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int PTR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int ADDR_W = 32;
  localparam int OP_W = 2;
  localparam int STATUS_W = 2;
  localparam int LEVEL_W = 6;
  localparam int COUNT_W = 7;

  localparam logic [OP_W-1:0] OP_ENTER = 2'd0;
  localparam logic [OP_W-1:0] OP_EXIT = 2'd1;
  localparam logic [OP_W-1:0] OP_DUMP = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic capture;
    logic exec;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic op_is_dump;
    logic empty;
    logic dump_last;
  } stat_t;

endpackage

`default_nettype wire

>>> design/scs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module scs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> design/scs_ctrl.sv
// Controller state machine of the shadow call stack checker.
// Depends on scs_pkg for the command and status types.
`default_nettype none

module scs_ctrl
  import scs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire stat_t stat,
  output logic       busy,
  output cmd_t       cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.op_is_dump && !stat.empty && !stat.dump_last) begin
          state_next = S_DUMP;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DUMP: begin
        cmd.step = 1'b1;
        if (stat.dump_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_capture_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.exec)
    else $error("capture not followed by execute");
  a_dump_only_on_dump: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> stat.op_is_dump && !stat.empty)
    else $error("dump step without a non-empty dump");
`endif

endmodule

`default_nettype wire

>>> design/scs_datapath.sv
// Datapath of the shadow call stack checker: stack memory, entry count,
// dump level and registered result word. Depends on scs_pkg and scs_ram.
`default_nettype none

module scs_datapath
  import scs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cmd_t                cmd,
  input  wire logic [OP_W-1:0]     opcode,
  input  wire logic [ADDR_W-1:0]   func_addr,
  output stat_t                    stat,
  output logic                     strobe,
  output logic      [STATUS_W-1:0] status,
  output logic                     entry_valid,
  output logic      [ADDR_W-1:0]   entry_addr,
  output logic      [LEVEL_W-1:0]  entry_level,
  output logic      [COUNT_W-1:0]  stack_depth,
  output logic                     last
);

  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  count_next;
  logic [LEVEL_W-1:0]  level;
  logic [LEVEL_W-1:0]  level_next;
  logic [OP_W-1:0]     op_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [ADDR_W-1:0]   rd_data;
  logic [PTR_W-1:0]    rd_addr;
  logic [COUNT_W-1:0]  rd_index;
  logic                we;
  logic                full;
  logic                empty;
  logic                dump_last;
  logic                dump_entry;
  logic                load;
  logic [STATUS_W-1:0] res_status;
  logic                res_valid;
  logic [ADDR_W-1:0]   res_addr;
  logic [LEVEL_W-1:0]  res_level;
  logic                res_last;

  assign full = (count == COUNT_W'(STACK_DEPTH));
  assign empty = (count == '0);
  assign dump_last = ({1'b0, level} == count - COUNT_W'(1));

  assign stat.op_is_dump = (op_q == OP_DUMP);
  assign stat.empty = empty;
  assign stat.dump_last = dump_last;

  assign dump_entry = cmd.step || (cmd.exec && (op_q == OP_DUMP) && !empty);

  always_comb begin
    if (cmd.capture) begin
      level_next = '0;
    end else if (dump_entry) begin
      level_next = level + LEVEL_W'(1);
    end else begin
      level_next = level;
    end
  end

  assign rd_index = count - COUNT_W'(1) - {1'b0, level_next};
  assign rd_addr = rd_index[PTR_W-1:0];

  always_comb begin
    count_next = count;
    we = 1'b0;
    load = 1'b0;
    res_status = ST_OK;
    res_valid = 1'b0;
    res_addr = '0;
    res_level = '0;
    res_last = 1'b1;
    if (dump_entry) begin
      load = 1'b1;
      res_valid = 1'b1;
      res_addr = {rd_data[ADDR_W-1:1], 1'b0};
      res_level = level;
      res_last = dump_last;
    end else if (cmd.exec) begin
      load = 1'b1;
      case (op_q)
        OP_ENTER: begin
          if (full) begin
            res_status = ST_FULL;
          end else begin
            we = 1'b1;
            count_next = count + COUNT_W'(1);
          end
        end
        OP_EXIT: begin
          if (empty) begin
            res_status = ST_EMPTY;
          end else if (rd_data != addr_q) begin
            res_status = ST_MISMATCH;
            res_valid = 1'b1;
            res_addr = rd_data;
          end else begin
            count_next = count - COUNT_W'(1);
          end
        end
        OP_DUMP: begin
          res_status = ST_EMPTY;
        end
        default: begin
          res_status = ST_OK;
        end
      endcase
    end
  end

  scs_ram #(
    .WIDTH(ADDR_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk  (clk),
    .we   (we),
    .waddr(count[PTR_W-1:0]),
    .wdata(addr_q),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      strobe <= 1'b0;
    end else begin
      count <= count_next;
      strobe <= load;
    end
  end

  always_ff @(posedge clk) begin
    level <= level_next;
    if (cmd.capture) begin
      op_q <= opcode;
      addr_q <= func_addr;
    end
    if (load) begin
      status <= res_status;
      entry_valid <= res_valid;
      entry_addr <= res_addr;
      entry_level <= res_level;
      stack_depth <= count_next;
      last <= res_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(STACK_DEPTH))
    else $error("entry count above stack depth");
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec || cmd.step) |=> strobe)
    else $error("no result word after a work step");
  a_full_depth: assert property (@(posedge clk) disable iff (rst)
    strobe && status == ST_FULL |-> stack_depth == COUNT_W'(STACK_DEPTH))
    else $error("full reported below stack depth");
  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    strobe && status == ST_EMPTY |-> stack_depth == '0 && !entry_valid)
    else $error("empty reported with entries held");
`endif

endmodule

`default_nettype wire

>>> design/shadow_call_stack_checker.sv
// Top level of the shadow call stack checker.
// Depends on scs_pkg, scs_ctrl and scs_datapath.
//
// Usage: drive opcode and func_addr with start high; the word is taken at a
// rising edge where start is high and busy is low. Enter pushes func_addr,
// exit pops when the top matches, dump lists every held entry.
// Each result word appears on status, entry_valid, entry_addr, entry_level,
// stack_depth and last for one cycle with strobe high; last marks the final
// word of a command. There is no back pressure: the receiver must take every
// word on the cycle it is shown.
// An enter or exit word is captured into op_q and addr_q, checked in the
// execute state and shown from the result registers; busy is high for one
// cycle, and no new command is taken until busy drops. The stack RAM has a
// registered read port and must return the top entry before an exit is checked.
// A dump of N entries shows N consecutive words from the execute state on
// and keeps busy high until its last word; an empty dump gives one word.
// Reset (rst, synchronous) empties the stack and drops strobe and busy; stack
// contents need no clearing since only pushed entries are ever read.
`default_nettype none

module shadow_call_stack_checker
  import scs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [OP_W-1:0]     opcode,
  input  wire logic [ADDR_W-1:0]   func_addr,
  output logic                     strobe,
  output logic      [STATUS_W-1:0] status,
  output logic                     entry_valid,
  output logic      [ADDR_W-1:0]   entry_addr,
  output logic      [LEVEL_W-1:0]  entry_level,
  output logic      [COUNT_W-1:0]  stack_depth,
  output logic                     last
);

  cmd_t  cmd;
  stat_t stat;

  scs_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .busy (busy),
    .cmd  (cmd)
  );

  scs_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .opcode     (opcode),
    .func_addr  (func_addr),
    .stat       (stat),
    .strobe     (strobe),
    .status     (status),
    .entry_valid(entry_valid),
    .entry_addr (entry_addr),
    .entry_level(entry_level),
    .stack_depth(stack_depth),
    .last       (last)
  );

endmodule

`default_nettype wire

>>> tb/sv/tb_shadow_call_stack_checker.sv
`timescale 1ns / 1ps
// Self-checking testbench of shadow_call_stack_checker: it drives enter, exit, dump and unused
// commands and checks every result word against a stack model kept in the bench.
// Depends on scs_pkg and on the design top shadow_call_stack_checker.

module tb_shadow_call_stack_checker
  import scs_pkg::*;
();

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
  } command_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                valid;
    logic [ADDR_W-1:0]   addr;
    logic [LEVEL_W-1:0]  level;
    logic [COUNT_W-1:0]  depth;
    logic                last;
  } stack_word_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [OP_W-1:0]     opcode = '0;
  logic [ADDR_W-1:0]   func_addr = '0;
  logic                busy;
  logic                strobe;
  logic [STATUS_W-1:0] status;
  logic                entry_valid;
  logic [ADDR_W-1:0]   entry_addr;
  logic [LEVEL_W-1:0]  entry_level;
  logic [COUNT_W-1:0]  stack_depth;
  logic                last;

  command_t          pending_cmds[$];
  logic [ADDR_W-1:0] plan_stack[$];
  stack_word_t       expected_words[$];
  logic [ADDR_W-1:0] shadow_mem[STACK_DEPTH];
  int unsigned       shadow_cnt = 0;
  int unsigned       n_queued = 0;
  int unsigned       n_accepted = 0;
  int unsigned       n_errors = 0;
  int unsigned       stall_cycles = 0;
  logic              take;
  command_t          cmd;
  stack_word_t       got_word;

  always #10 clk = ~clk;

  shadow_call_stack_checker i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .func_addr   (func_addr),
    .strobe      (strobe),
    .status      (status),
    .entry_valid (entry_valid),
    .entry_addr  (entry_addr),
    .entry_level (entry_level),
    .stack_depth (stack_depth),
    .last        (last)
  );

  function automatic void expect_word(logic [STATUS_W-1:0] st, logic valid,
                                      logic [ADDR_W-1:0] addr, logic [LEVEL_W-1:0] level,
                                      logic fin);
    stack_word_t w;
    w.status = st;
    w.valid = valid;
    w.addr = addr;
    w.level = level;
    w.depth = shadow_cnt[COUNT_W-1:0];
    w.last = fin;
    expected_words.push_back(w);
  endfunction

  function automatic void predict_stack_results(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] top;
    case (op)
      OP_ENTER: begin
        if (shadow_cnt >= STACK_DEPTH) begin
          expect_word(ST_FULL, 1'b0, '0, '0, 1'b1);
        end else begin
          shadow_mem[shadow_cnt] = addr;
          shadow_cnt++;
          expect_word(ST_OK, 1'b0, '0, '0, 1'b1);
        end
      end
      OP_EXIT: begin
        if (shadow_cnt == 0) begin
          expect_word(ST_EMPTY, 1'b0, '0, '0, 1'b1);
        end else begin
          top = shadow_mem[shadow_cnt-1];
          if (top != addr) begin
            expect_word(ST_MISMATCH, 1'b1, top, '0, 1'b1);
          end else begin
            shadow_cnt--;
            expect_word(ST_OK, 1'b0, '0, '0, 1'b1);
          end
        end
      end
      OP_DUMP: begin
        if (shadow_cnt == 0) begin
          expect_word(ST_EMPTY, 1'b0, '0, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < shadow_cnt; i++) begin
            top = shadow_mem[shadow_cnt-1-i];
            expect_word(ST_OK, 1'b1, {top[ADDR_W-1:1], 1'b0}, i[LEVEL_W-1:0],
                        i + 1 == shadow_cnt);
          end
        end
      end
      default: begin
        expect_word(ST_OK, 1'b0, '0, '0, 1'b1);
      end
    endcase
  endfunction

  function automatic void queue_cmd(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr);
    command_t c;
    c.op = op;
    c.addr = addr;
    pending_cmds.push_back(c);
    n_queued++;
    if (op == OP_ENTER && plan_stack.size() < STACK_DEPTH) begin
      plan_stack.push_back(addr);
    end else if (op == OP_EXIT && plan_stack.size() != 0 && plan_stack[$] == addr) begin
      void'(plan_stack.pop_back());
    end
  endfunction

  task automatic check_field(string name, logic [ADDR_W-1:0] exp_val,
                             logic [ADDR_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      take = start && !busy;
      if (take) begin
        predict_stack_results(opcode, func_addr);
        n_accepted++;
      end
      if (take || !start) begin
        if (pending_cmds.size() != 0 &&
            ((n_accepted >= 40 && n_accepted < 100) || $urandom_range(0, 99) >= 8)) begin
          cmd = pending_cmds.pop_front();
          start <= 1'b1;
          opcode <= cmd.op;
          func_addr <= cmd.addr;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual status %0d addr %h last %0d",
                 $time, status, entry_addr, last);
        n_errors++;
      end else begin
        got_word = expected_words.pop_front();
        check_field("status", ADDR_W'(got_word.status), ADDR_W'(status));
        check_field("entry_valid", ADDR_W'(got_word.valid), ADDR_W'(entry_valid));
        check_field("entry_addr", got_word.addr, entry_addr);
        check_field("entry_level", ADDR_W'(got_word.level), ADDR_W'(entry_level));
        check_field("stack_depth", ADDR_W'(got_word.depth), ADDR_W'(stack_depth));
        check_field("last", ADDR_W'(got_word.last), ADDR_W'(last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("shadow_call_stack_checker regression: fail");
    $finish;
  end

  initial begin
    logic [ADDR_W-1:0] a;
    int unsigned r;
    queue_cmd(OP_EXIT, 32'h0000_1000);
    queue_cmd(OP_DUMP, 32'h0000_0000);
    queue_cmd(OP_ENTER, 32'h0000_0000);
    queue_cmd(OP_ENTER, 32'hFFFF_FFFF);
    queue_cmd(OP_ENTER, 32'h8000_0001);
    queue_cmd(OP_UNUSED, 32'hFFFF_FFFF);
    queue_cmd(OP_DUMP, 32'hFFFF_FFFF);
    // The top differs from this address only in bit 0.
    queue_cmd(OP_EXIT, 32'h8000_0000);
    queue_cmd(OP_EXIT, 32'h8000_0001);
    queue_cmd(OP_EXIT, 32'h0000_0000);
    queue_cmd(OP_EXIT, 32'hFFFF_FFFF);
    queue_cmd(OP_EXIT, 32'h0000_0000);
    queue_cmd(OP_DUMP, 32'h0000_0000);
    queue_cmd(OP_EXIT, 32'hFFFF_FFFF);
    for (int k = 0; k < 20; k++) begin
      if (k == 10) begin
        // Fill the stack, push past the top, dump all of it, then exit on a mismatch.
        while (plan_stack.size() < STACK_DEPTH) queue_cmd(OP_ENTER, $urandom());
        repeat (2) queue_cmd(OP_ENTER, $urandom());
        queue_cmd(OP_DUMP, $urandom());
        queue_cmd(OP_EXIT, plan_stack[$] ^ 32'h1);
      end
      r = $urandom_range(0, 99);
      if (r < 45) begin
        queue_cmd(OP_ENTER, $urandom());
      end else if (r < 78 && plan_stack.size() != 0) begin
        queue_cmd(OP_EXIT, plan_stack[$]);
      end else if (r < 86) begin
        a = $urandom();
        if (plan_stack.size() != 0 && r[0]) begin
          a = plan_stack[$] ^ (32'h1 << $urandom_range(0, 31));
        end
        queue_cmd(OP_EXIT, a);
      end else if (r < 94) begin
        queue_cmd(OP_DUMP, $urandom());
      end else if (r < 97) begin
        queue_cmd(OP_UNUSED, $urandom());
      end else begin
        queue_cmd(OP_EXIT, $urandom());
      end
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (n_accepted < n_queued || expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("shadow_call_stack_checker regression: pass");
    end else begin
      $display("shadow_call_stack_checker regression: fail");
    end
    $finish;
  end

endmodule
